// File: design/cdsp_pkg.sv
// ----------------------------------------------------------------------------
// cdsp_pkg
// shared types and codes of the strided, zero-padded 2d convolution block
// ----------------------------------------------------------------------------
package cdsp_pkg;

    localparam int OUT_W = 37;

    localparam logic [1:0] REQ_FILTER  = 2'd0;
    localparam logic [1:0] REQ_PIXEL   = 2'd1;
    localparam logic [1:0] REQ_COMPUTE = 2'd2;

    localparam logic [1:0] CFG_FILTER_SIZE = 2'd0;
    localparam logic [1:0] CFG_STRIDE      = 2'd1;
    localparam logic [1:0] CFG_PADDING     = 2'd2;
    localparam logic [1:0] CFG_IMAGE_SIZE  = 2'd3;

    localparam logic [2:0] RST_FILTER_SIZE = 3'd3;
    localparam logic [3:0] RST_STRIDE      = 4'd1;
    localparam logic [1:0] RST_PADDING     = 2'd0;
    localparam logic [6:0] RST_IMAGE_SIZE  = 7'd32;

    typedef struct packed {
        logic [7:0] n;
        logic [3:0] f;
        logic [3:0] stride;
        logic [1:0] pad;
    } geom_t;

    typedef struct packed {
        logic clear;
        logic issue;
        logic inbound;
    } mac_ctl_t;

    typedef struct packed {
        logic valid;
        logic bad;
    } fin_t;

endpackage

// File: design/cdsp_ram.sv
// ----------------------------------------------------------------------------
// cdsp_ram
// single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module cdsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/cdsp_mac.sv
// ----------------------------------------------------------------------------
// cdsp_mac
// shared multiply-accumulate: product register, then accumulator
// ----------------------------------------------------------------------------
module cdsp_mac #(
    parameter int PIX_W = 16,
    parameter int ACC_W = 40
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cdsp_pkg::mac_ctl_t      ctl,
    input  logic signed [PIX_W-1:0] pixel,
    input  logic signed [15:0]      tap,
    output logic signed [ACC_W-1:0] acc
);
    import cdsp_pkg::*;

    localparam int PROD_W = PIX_W + 16;

    logic                     issue_d1_reg;
    logic                     inb_d1_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    // operands arrive in the cycle after the address, with the ram read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_d1_reg <= 1'b0;
            inb_d1_reg   <= 1'b0;
        end else begin
            issue_d1_reg <= ctl.issue;
            inb_d1_reg   <= ctl.inbound;
        end
    end

    always_comb begin
        prod_next = '0;
        if (!ctl.clear && issue_d1_reg && inb_d1_reg) begin
            prod_next = pixel * tap;
        end
        acc_next = ctl.clear ? '0 : acc_reg + ACC_W'(prod_reg);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// File: design/cdsp_seq.sv
// ----------------------------------------------------------------------------
// cdsp_seq
// request sequencer: map bound check and filter tap walk with address gen
// ----------------------------------------------------------------------------
module cdsp_seq #(
    parameter int MAX_IMAGE  = 64,
    parameter int MAX_FILTER = 7
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [6:0]                          row,
    input  logic [6:0]                          col,
    input  cdsp_pkg::geom_t                     geom,
    input  logic                                out_free,
    output logic                                idle,
    output logic [2*$clog2(MAX_IMAGE)-1:0]      img_raddr,
    output logic [2*((MAX_FILTER > 1) ? $clog2(MAX_FILTER) : 1)-1:0] flt_raddr,
    output cdsp_pkg::mac_ctl_t                  mac_ctl,
    output cdsp_pkg::fin_t                      fin
);
    import cdsp_pkg::*;

    localparam int CW = $clog2(MAX_IMAGE);
    localparam int FW = (MAX_FILTER > 1) ? $clog2(MAX_FILTER) : 1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_WALK   = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t         state_reg, state_next;
    logic [10:0]    org_r_reg, org_r_next;
    logic [10:0]    org_c_reg, org_c_next;
    logic [FW-1:0]  k_reg, k_next;
    logic [FW-1:0]  q_reg, q_next;
    logic           drain_reg, drain_next;
    logic           bad_reg, bad_next;

    logic [12:0]    ir;
    logic [12:0]    ic;
    logic [11:0]    limit;
    logic           fit_r;
    logic           fit_c;
    logic           inb;
    logic           k_last;
    logic           q_last;

    always_comb begin
        ir     = {2'b00, org_r_reg} + 13'(k_reg) - 13'(geom.pad);
        ic     = {2'b00, org_c_reg} + 13'(q_reg) - 13'(geom.pad);
        limit  = 12'(geom.n) + 12'({geom.pad, 1'b0});
        fit_r  = ({1'b0, org_r_reg} + 12'(geom.f)) <= limit;
        fit_c  = ({1'b0, org_c_reg} + 12'(geom.f)) <= limit;
        inb    = !ir[12] && !ic[12] && (ir[11:0] < 12'(geom.n)) && (ic[11:0] < 12'(geom.n));
        k_last = 4'(k_reg) == (geom.f - 4'd1);
        q_last = 4'(q_reg) == (geom.f - 4'd1);
    end

    always_comb begin
        state_next = state_reg;
        org_r_next = org_r_reg;
        org_c_next = org_c_reg;
        k_next     = k_reg;
        q_next     = q_reg;
        drain_next = drain_reg;
        bad_next   = bad_reg;
        mac_ctl    = '0;
        fin        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    org_r_next = 11'(row) * 11'(geom.stride);
                    org_c_next = 11'(col) * 11'(geom.stride);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                mac_ctl.clear = 1'b1;
                k_next        = '0;
                q_next        = '0;
                if (fit_r && fit_c) begin
                    bad_next   = 1'b0;
                    state_next = ST_WALK;
                end else begin
                    bad_next   = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_WALK: begin
                mac_ctl.issue   = 1'b1;
                mac_ctl.inbound = inb;
                if (q_last) begin
                    q_next = '0;
                    k_next = k_reg + FW'(1);
                    if (k_last) begin
                        drain_next = 1'b0;
                        state_next = ST_DRAIN;
                    end
                end else begin
                    q_next = q_reg + FW'(1);
                end
            end
            ST_DRAIN: begin
                drain_next = 1'b1;
                if (drain_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                fin.valid = out_free;
                fin.bad   = bad_reg;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            drain_reg <= 1'b0;
            bad_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            drain_reg <= drain_next;
            bad_reg   <= bad_next;
        end
    end

    always_ff @(posedge aclk) begin
        org_r_reg <= org_r_next;
        org_c_reg <= org_c_next;
        k_reg     <= k_next;
        q_reg     <= q_next;
    end

    assign idle      = (state_reg == ST_IDLE);
    assign img_raddr = {ir[CW-1:0], ic[CW-1:0]};
    assign flt_raddr = {k_reg, q_reg};

endmodule

// File: design/conv2d_stride_pad.sv
// ----------------------------------------------------------------------------
// conv2d_stride_pad
// square 2d cross-correlation with stride and zero padding over stored data
// ----------------------------------------------------------------------------
// A write item (filter tap or pixel) is taken while the block is idle and
// gives no result. A compute item names an output map coordinate; the block
// checks it against the map bound, walks the F x F taps through one shared
// multiply-accumulate, one tap per cycle, drains it and hands the result on
// once an earlier result is taken; only then does it take the next item
// (after the check alone when the coordinate lies outside the map). Walk
// length and the single multiplier set the busy time. A finished result sits
// in an output register, so writes are taken while it waits.
// Image and filter stores have no reset: compute only over written entries.
module conv2d_stride_pad #(
    parameter int MAX_IMAGE  = 64,
    parameter int MAX_FILTER = 7,
    parameter int PIXEL_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // row[6:0], col[13:7], value[29:14], zero
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_value[36:0], zero
    output logic [0:0]  m_tuser,   // status[0]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [6:0]  cfg_data
);
    import cdsp_pkg::*;

    localparam int CW      = $clog2(MAX_IMAGE);
    localparam int FW      = (MAX_FILTER > 1) ? $clog2(MAX_FILTER) : 1;
    localparam int PIX_W   = (PIXEL_BITS < 16) ? PIXEL_BITS : 16;
    localparam int ACC_RAW = PIX_W + 16 + $clog2(MAX_FILTER * MAX_FILTER + 1);
    localparam int ACC_W   = (ACC_RAW > OUT_W) ? ACC_RAW : OUT_W + 1;

    localparam logic signed [ACC_W-1:0] OUT_HI =
        {{(ACC_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] OUT_LO = ~OUT_HI;
    localparam logic signed [15:0] PIX_HI = {{(17 - PIX_W){1'b0}}, {(PIX_W - 1){1'b1}}};
    localparam logic signed [15:0] PIX_LO = ~PIX_HI;

    logic [2:0]  fs_reg;
    logic [3:0]  stride_reg;
    logic [1:0]  pad_reg;
    logic [6:0]  img_reg;
    geom_t       geom;

    logic        s_acc;
    logic [1:0]  req;
    logic [6:0]  s_row;
    logic [6:0]  s_col;
    logic signed [15:0] s_value;
    logic signed [15:0] pix_sat;

    logic        flt_we;
    logic        img_we;
    logic        idle;
    logic        out_free;
    logic [2*CW-1:0]    img_raddr;
    logic [2*FW-1:0]    flt_raddr;
    logic [PIX_W-1:0]   img_rdata;
    logic [15:0]        flt_rdata;
    mac_ctl_t           mac_ctl;
    fin_t               fin;
    logic signed [ACC_W-1:0] acc;
    logic [OUT_W-1:0]   acc_sat;

    logic               m_valid_reg;
    logic [OUT_W-1:0]   m_data_reg;
    logic               m_status_reg;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fs_reg     <= RST_FILTER_SIZE;
            stride_reg <= RST_STRIDE;
            pad_reg    <= RST_PADDING;
            img_reg    <= RST_IMAGE_SIZE;
        end else if (cfg_we) begin
            case (cfg_idx)
                CFG_FILTER_SIZE: fs_reg     <= cfg_data[2:0];
                CFG_STRIDE:      stride_reg <= cfg_data[3:0];
                CFG_PADDING:     pad_reg    <= cfg_data[1:0];
                CFG_IMAGE_SIZE:  img_reg    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // clamp config to usable range
    always_comb begin
        if (img_reg == 7'd0) begin
            geom.n = 8'd1;
        end else if (32'(img_reg) > MAX_IMAGE) begin
            geom.n = 8'(MAX_IMAGE);
        end else begin
            geom.n = 8'(img_reg);
        end
        if (fs_reg == 3'd0) begin
            geom.f = 4'd1;
        end else if (32'(fs_reg) > MAX_FILTER) begin
            geom.f = 4'(MAX_FILTER);
        end else begin
            geom.f = 4'(fs_reg);
        end
        geom.stride = (stride_reg == 4'd0) ? 4'd1 : stride_reg;
        geom.pad    = pad_reg;
    end

    // input item decode and store writes
    assign req      = s_tuser;
    assign s_row    = s_tdata[6:0];
    assign s_col    = s_tdata[13:7];
    assign s_value  = s_tdata[29:14];
    assign s_tready = idle;
    assign s_acc    = s_tvalid && s_tready;

    always_comb begin
        if (s_value > PIX_HI) begin
            pix_sat = PIX_HI;
        end else if (s_value < PIX_LO) begin
            pix_sat = PIX_LO;
        end else begin
            pix_sat = s_value;
        end
    end

    assign flt_we = s_acc && (req == REQ_FILTER)
                    && (32'(s_row) < MAX_FILTER) && (32'(s_col) < MAX_FILTER);
    assign img_we = s_acc && (req == REQ_PIXEL)
                    && (32'(s_row) < MAX_IMAGE) && (32'(s_col) < MAX_IMAGE);

    cdsp_ram #(
        .WIDTH (PIX_W),
        .DEPTH (1 << (2 * CW))
    ) u_img_ram (
        .aclk  (aclk),
        .we    (img_we),
        .waddr ({CW'(s_row), CW'(s_col)}),
        .wdata (pix_sat[PIX_W-1:0]),
        .raddr (img_raddr),
        .rdata (img_rdata)
    );

    cdsp_ram #(
        .WIDTH (16),
        .DEPTH (1 << (2 * FW))
    ) u_flt_ram (
        .aclk  (aclk),
        .we    (flt_we),
        .waddr ({FW'(s_row), FW'(s_col)}),
        .wdata (s_value),
        .raddr (flt_raddr),
        .rdata (flt_rdata)
    );

    cdsp_seq #(
        .MAX_IMAGE  (MAX_IMAGE),
        .MAX_FILTER (MAX_FILTER)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_acc && (req == REQ_COMPUTE)),
        .row       (s_row),
        .col       (s_col),
        .geom      (geom),
        .out_free  (out_free),
        .idle      (idle),
        .img_raddr (img_raddr),
        .flt_raddr (flt_raddr),
        .mac_ctl   (mac_ctl),
        .fin       (fin)
    );

    cdsp_mac #(
        .PIX_W (PIX_W),
        .ACC_W (ACC_W)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .pixel   (img_rdata),
        .tap     (flt_rdata),
        .acc     (acc)
    );

    // output register
    always_comb begin
        if (acc > OUT_HI) begin
            acc_sat = OUT_HI[OUT_W-1:0];
        end else if (acc < OUT_LO) begin
            acc_sat = OUT_LO[OUT_W-1:0];
        end else begin
            acc_sat = acc[OUT_W-1:0];
        end
    end

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin.valid) begin
            m_data_reg   <= fin.bad ? '0 : acc_sat;
            m_status_reg <= fin.bad;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_data_reg};
    assign m_tuser  = m_status_reg;

endmodule

// File: design/cdsp_chk.sv
// ----------------------------------------------------------------------------
// cdsp_chk
// port-level checks of the convolution block, bound to the top level
// ----------------------------------------------------------------------------
module cdsp_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        cfg_we,
    input logic [1:0]  cfg_idx,
    input logic [6:0]  cfg_data
);
    import cdsp_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 40'd0)
        else $error("out-of-map result carries nonzero value");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == REQ_COMPUTE) |=> !s_tready)
        else $error("ready right after a compute item");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[39:37] == 3'd0)
        else $error("result padding bits set");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind conv2d_stride_pad cdsp_chk u_cdsp_chk (.*);

// File: dv/conv2d_stride_pad_tb.sv
// ----------------------------------------------------------------------------
// conv2d_stride_pad_tb
// self-checking bench for the strided, zero-padded 2d convolution block
// ----------------------------------------------------------------------------
// Items go in on the s_ stream with random gaps. Results are taken on the m_
// stream under random back-pressure. A scoreboard keeps its own filter, image
// and geometry registers, predicts the sum and status of each compute item,
// and checks results in order. The geometry is only rewritten once the block
// has gone quiet, and the extremes of every register are visited. The stores
// have no reset, so every filter tap and in-image pixel that a compute window
// covers is written before the compute item goes in.
// ----------------------------------------------------------------------------
module conv2d_stride_pad_tb;
    import cdsp_pkg::*;

    localparam int IMG_MAX    = 64;
    localparam int FLT_MAX    = 7;
    localparam int DRAIN      = 64;
    localparam int MAX_CYCLES = 3_000_000;
    localparam int SHOW_LIMIT = 10;
    localparam longint SUM_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;

    localparam logic [1:0] REQ_NONE       = 2'd3;
    localparam logic       STATUS_OK      = 1'b0;
    localparam logic       STATUS_OUTSIDE = 1'b1;

    typedef struct {
        logic [OUT_W-1:0] sum;
        logic             status;
    } conv_result_t;

    class conv_scoreboard;
        logic signed [15:0] taps [FLT_MAX*FLT_MAX];
        bit                 tap_known [FLT_MAX*FLT_MAX];
        logic signed [15:0] pixels [IMG_MAX*IMG_MAX];
        bit                 pixel_known [IMG_MAX*IMG_MAX];
        logic [2:0]         f_reg;
        logic [3:0]         s_reg;
        logic [1:0]         p_reg;
        logic [6:0]         n_reg;
        conv_result_t       expected_sums [$];
        int                 errors;
        int                 tap_writes;
        int                 pixel_writes;
        int                 sums_inside;
        int                 sums_outside;

        function new();
            f_reg = RST_FILTER_SIZE;
            s_reg = RST_STRIDE;
            p_reg = RST_PADDING;
            n_reg = RST_IMAGE_SIZE;
        endfunction

        function void set_reg(logic [1:0] idx, logic [6:0] d);
            case (idx)
                CFG_FILTER_SIZE: f_reg = d[2:0];
                CFG_STRIDE:      s_reg = d[3:0];
                CFG_PADDING:     p_reg = d[1:0];
                CFG_IMAGE_SIZE:  n_reg = d;
                default: ;
            endcase
        endfunction

        function int side_f();
            return (f_reg == 0) ? 1 : int'(f_reg);
        endfunction

        function int step_s();
            return (s_reg == 0) ? 1 : int'(s_reg);
        endfunction

        function int pad_p();
            return int'(p_reg);
        endfunction

        function int side_n();
            if (n_reg == 0) return 1;
            if (n_reg > IMG_MAX) return IMG_MAX;
            return int'(n_reg);
        endfunction

        function int map_side();
            int span;
            span = side_n() + 2 * pad_p();
            if (span < side_f()) return 0;
            return (span - side_f()) / step_s() + 1;
        endfunction

        function logic [OUT_W-1:0] window_sum(int r, int c);
            longint acc;
            int     ir;
            int     ic;
            acc = 0;
            for (int k = 0; k < side_f(); k++) begin
                for (int q = 0; q < side_f(); q++) begin
                    ir = r * step_s() + k - pad_p();
                    ic = c * step_s() + q - pad_p();
                    // padding border reads as zero
                    if (ir >= 0 && ir < side_n() && ic >= 0 && ic < side_n()) begin
                        acc += longint'(pixels[ir*IMG_MAX + ic]) *
                               longint'(taps[k*FLT_MAX + q]);
                    end
                end
            end
            if (acc > SUM_MAX) acc = SUM_MAX;
            if (acc < -SUM_MAX - 1) acc = -SUM_MAX - 1;
            return acc[OUT_W-1:0];
        endfunction

        // returns 1 when the item has an effect on the block
        function bit note_item(logic [1:0] kind, logic [6:0] r, logic [6:0] c,
                               logic [15:0] v);
            conv_result_t res;
            case (kind)
                REQ_FILTER: begin
                    if (r >= FLT_MAX || c >= FLT_MAX) return 0;
                    taps[r*FLT_MAX + c] = v;
                    tap_known[r*FLT_MAX + c] = 1'b1;
                    tap_writes++;
                    return 1;
                end
                REQ_PIXEL: begin
                    if (r >= IMG_MAX || c >= IMG_MAX) return 0;
                    pixels[r*IMG_MAX + c] = v;
                    pixel_known[r*IMG_MAX + c] = 1'b1;
                    pixel_writes++;
                    return 1;
                end
                REQ_COMPUTE: begin
                    if (r >= map_side() || c >= map_side()) begin
                        res.sum = '0;
                        res.status = STATUS_OUTSIDE;
                        sums_outside++;
                    end else begin
                        res.sum = window_sum(int'(r), int'(c));
                        res.status = STATUS_OK;
                        sums_inside++;
                    end
                    expected_sums.insert(expected_sums.size(), res);
                    return 1;
                end
                default: return 0;
            endcase
        endfunction

        function void check_result(logic [OUT_W-1:0] got_sum, logic got_status);
            conv_result_t want;
            if (expected_sums.size() == 0) begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("unexpected result: sum %0d status %0d",
                             $signed(got_sum), got_status);
                return;
            end
            want = expected_sums.pop_front();
            if (got_sum !== want.sum || got_status !== want.status) begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("mismatch: expected sum %0d status %0d, got sum %0d status %0d",
                             $signed(want.sum), want.status, $signed(got_sum), got_status);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // row[6:0], col[13:7], value[29:14], zero
    logic [1:0]  s_tuser;   // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;   // out_value[36:0], zero
    logic [0:0]  m_tuser;   // status[0]
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [6:0]  cfg_data;

    conv_scoreboard sb;
    int             cycle_count = 0;
    int             live_items  = 0;
    int             geometries  = 0;
    int             stall_left  = 0;
    bit             calm        = 1'b0;

    conv2d_stride_pad uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == MAX_CYCLES) begin
            $display("[conv2d_stride_pad] ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // result side back-pressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            stall_left <= pick_gap();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[OUT_W-1:0], m_tuser[0]);
    end

    task automatic send_item(logic [1:0] kind, logic [6:0] r, logic [6:0] c,
                             logic [15:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, v, c, r};
        do @(posedge aclk); while (!s_tready);
        if (sb.note_item(kind, r, c, v)) live_items++;
    endtask

    // write whatever the window still lacks, then ask for the sum
    task automatic compute_at(int r, int c);
        int ir;
        int ic;
        if (r < sb.map_side() && c < sb.map_side()) begin
            for (int k = 0; k < sb.side_f(); k++) begin
                for (int q = 0; q < sb.side_f(); q++) begin
                    if (!sb.tap_known[k*FLT_MAX + q])
                        send_item(REQ_FILTER, 7'(k), 7'(q), pick_value());
                    ir = r * sb.step_s() + k - sb.pad_p();
                    ic = c * sb.step_s() + q - sb.pad_p();
                    if (ir >= 0 && ir < sb.side_n() && ic >= 0 && ic < sb.side_n() &&
                        !sb.pixel_known[ir*IMG_MAX + ic])
                        send_item(REQ_PIXEL, 7'(ir), 7'(ic), pick_value());
                end
            end
        end
        send_item(REQ_COMPUTE, 7'(r), 7'(c), 16'($urandom));
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] d);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= d;
        @(posedge aclk);
        sb.set_reg(idx, d);
    endtask

    task automatic set_geometry(logic [2:0] f, logic [3:0] s, logic [1:0] p,
                                logic [6:0] n);
        write_reg(CFG_FILTER_SIZE, 7'(f));
        write_reg(CFG_STRIDE, 7'(s));
        write_reg(CFG_PADDING, 7'(p));
        write_reg(CFG_IMAGE_SIZE, n);
        cfg_we <= 1'b0;
        geometries++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.expected_sums.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic random_items(int budget);
        int target;
        int map;
        int pick;
        target = live_items + budget;
        while (live_items < target) begin
            map = sb.map_side();
            pick = $urandom_range(0, 99);
            if (pick < 40 && map > 0) begin
                compute_at($urandom_range(0, map - 1), $urandom_range(0, map - 1));
            end else if (pick < 45) begin
                compute_at($urandom_range(0, 127), $urandom_range(0, 127));
            end else if (pick < 50) begin
                // just past the map edge
                if ($urandom_range(0, 1) == 0)
                    compute_at(map, $urandom_range(0, 127));
                else
                    compute_at($urandom_range(0, 127), map);
            end else if (pick < 70) begin
                send_item(REQ_PIXEL, 7'($urandom_range(0, sb.side_n() - 1)),
                          7'($urandom_range(0, sb.side_n() - 1)), pick_value());
            end else if (pick < 82) begin
                send_item(REQ_FILTER, 7'($urandom_range(0, sb.side_f() - 1)),
                          7'($urandom_range(0, sb.side_f() - 1)), pick_value());
            end else if (pick < 86) begin
                send_item(REQ_PIXEL, 7'($urandom_range(0, IMG_MAX - 1)),
                          7'($urandom_range(0, IMG_MAX - 1)), pick_value());
            end else if (pick < 90) begin
                send_item(REQ_FILTER, 7'($urandom_range(0, FLT_MAX - 1)),
                          7'($urandom_range(0, FLT_MAX - 1)), pick_value());
            end else begin
                case ($urandom_range(0, 2))
                    0: send_item(REQ_FILTER, 7'($urandom_range(FLT_MAX, 127)),
                                 7'($urandom), pick_value());
                    1: send_item(REQ_PIXEL, 7'($urandom),
                                 7'($urandom_range(IMG_MAX, 127)), pick_value());
                    default: send_item(REQ_NONE, 7'($urandom), 7'($urandom),
                                       16'($urandom));
                endcase
            end
        end
    endtask

    task automatic run_phase(logic [2:0] f, logic [3:0] s, logic [1:0] p,
                             logic [6:0] n, int budget);
        calm = ($urandom_range(0, 3) == 0);
        set_geometry(f, s, p, n);
        random_items(budget);
        settle();
    endtask

    // full-scale taps and pixels over a 7x7 window, both signs of the sum
    task automatic full_scale_sums();
        calm = 1'b0;
        set_geometry(3'd7, 4'd1, 2'd0, 7'd7);
        for (int k = 0; k < FLT_MAX; k++) begin
            for (int q = 0; q < FLT_MAX; q++) begin
                send_item(REQ_FILTER, 7'(k), 7'(q), 16'h8000);
                send_item(REQ_PIXEL, 7'(k), 7'(q), 16'h8000);
            end
        end
        send_item(REQ_COMPUTE, 7'd0, 7'd0, 16'h0000);
        for (int k = 0; k < FLT_MAX; k++) begin
            for (int q = 0; q < FLT_MAX; q++) begin
                send_item(REQ_FILTER, 7'(k), 7'(q), 16'h7FFF);
            end
        end
        send_item(REQ_COMPUTE, 7'd0, 7'd0, 16'hFFFF);
        settle();
    endtask

    initial begin
        sb = new();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        cfg_we   <= 1'b0;
        cfg_idx  <= '0;
        cfg_data <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset geometry: 3x3 filter, stride 1, no padding, 32x32 image
        send_item(REQ_FILTER, 7'd127, 7'd127, 16'h7FFF);
        send_item(REQ_FILTER, 7'd7, 7'd0, 16'h8000);
        send_item(REQ_FILTER, 7'd0, 7'd7, 16'h1234);
        send_item(REQ_PIXEL, 7'd64, 7'd0, 16'h7FFF);
        send_item(REQ_PIXEL, 7'd0, 7'd127, 16'h8000);
        send_item(REQ_NONE, 7'd127, 7'd127, 16'hFFFF);
        compute_at(0, 0);
        compute_at(29, 29);
        compute_at(30, 0);
        compute_at(0, 30);
        compute_at(127, 127);
        send_item(REQ_FILTER, 7'd0, 7'd0, 16'h7FFF);
        send_item(REQ_PIXEL, 7'd0, 7'd0, 16'h8000);
        send_item(REQ_PIXEL, 7'd63, 7'd63, 16'h7FFF);
        compute_at(0, 0);
        settle();

        run_phase(3'd0, 4'd0, 2'd0, 7'd0, 40);      // zero sizes and stride
        run_phase(3'd7, 4'd15, 2'd3, 7'd12, 50);    // widest stride and border
        run_phase(3'd7, 4'd1, 2'd0, 7'd1, 30);      // filter wider than padded image
        run_phase(3'd1, 4'd8, 2'd3, 7'd127, 60);    // image size saturates
        run_phase(3'd3, 4'd2, 2'd1, 7'd64, 60);
        full_scale_sums();
        for (int ph = 0; ph < 6; ph++) begin
            run_phase(3'($urandom_range(0, 7)),
                      ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(1, 3)),
                      2'($urandom_range(0, 3)),
                      ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                                  : 7'($urandom_range(1, 12)),
                      80);
        end

        $display("run covered %0d tap writes, %0d pixel writes, %0d in-map sums, %0d off-map",
                 sb.tap_writes, sb.pixel_writes, sb.sums_inside, sb.sums_outside);
        $display("over %0d geometry settings; %0d mismatches", geometries, sb.errors);
        if (sb.errors == 0) begin
            $display("[conv2d_stride_pad] OK");
        end else begin
            $display("[conv2d_stride_pad] ERROR");
        end
        $finish;
    end

endmodule
